// ===== design/tilt_angle_estimator_defines.svh =====
// Assertion macros for the tilt angle estimator.
// Included by the top level; no other dependencies.
`ifndef TILT_ANGLE_ESTIMATOR_DEFINES_SVH
`define TILT_ANGLE_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TAE_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tilt_angle_estimator: check failed");
`define TAE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tilt_angle_estimator: check failed");
`else
`define TAE_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define TAE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== design/tae_pkg.sv =====
// Shared constants, types and the arctangent table of the tilt angle estimator.
// No dependencies.
`default_nettype none

package tae_pkg;

   localparam int CORDIC_ITERATIONS_DEFAULT = 16;

   // CORDIC datapath: operands are raw values shifted up by 16, angles in Q16 degrees
   localparam int OPND_W     = 36;
   localparam int ANGLE_W    = 27;
   localparam int ATAN_W     = 22;
   localparam int ATAN_IDX_W = 5;

   localparam logic signed [ANGLE_W-1:0] DEG90  = 27'sd5898240;
   localparam logic signed [ANGLE_W-1:0] DEG180 = 27'sd11796480;

   // Integer square root of {radicand, 32 zero bits}
   localparam int SQRT_IN_W  = 32;
   localparam int SQRT_REM_W = 36;
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_CNT_W = 5;

   // Yaw increment: round(|gyro| * 65536 / 13100) through a reciprocal
   localparam int YAW_NUM_W   = 32;
   localparam int YAW_Q_W     = 18;
   localparam int YAW_ACC_W   = 48;
   localparam int YAW_OUT_W   = 32;
   localparam int YAW_SHIFT   = 45;
   localparam logic [13:0]          YAW_DIV   = 14'd13100;
   localparam logic [YAW_NUM_W-1:0] YAW_HALF  = 32'd6550;
   localparam logic [YAW_NUM_W-1:0] YAW_RECIP = 32'd2685829930;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // atan(2^-i) in Q16 degrees, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== design/tilt_angle_estimator.sv =====
// Top level of the tilt angle estimator: sequencer, squares, output register.
// Depends on tae_pkg, tae_cordic, tae_isqrt, tae_yaw and the assertion macro header.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  accel_x, accel_y, accel_z, gyro_z
//   rsp_      out        rsp_valid/rsp_stall  roll_angle, pitch_angle, yaw_angle
//
// A transaction computes the squares, then the bit-serial square root (the CORDIC runs roll
// meanwhile), then pitch on the same CORDIC, and last loads the result.
// req_stall is high from accept until the result is loaded; a held result does not block
// the next transaction, only the loading of its result.
// Reset is synchronous and clears the yaw accumulator; no clearing pass is needed.
`default_nettype none
`include "tilt_angle_estimator_defines.svh"

module tilt_angle_estimator #(
   parameter int CORDIC_ITERATIONS = tae_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   input  wire logic signed [15:0] req_gyro_z,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic signed [16:0]  rsp_roll_angle,
   output logic signed [15:0]  rsp_pitch_angle,
   output logic signed [31:0]  rsp_yaw_angle
);

   localparam int RND_W = tae_pkg::ANGLE_W - 7;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQUARE = 3'd1;
   localparam logic [2:0] S_SUM    = 3'd2;
   localparam logic [2:0] S_ROOT   = 3'd3;
   localparam logic [2:0] S_PGO    = 3'd4;
   localparam logic [2:0] S_PITCH  = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;

   logic [2:0]                            state_ff, state_in;
   logic signed [15:0]                    ax_ff, ay_ff, az_ff;
   logic [31:0]                           sq_y_ff, sq_z_ff;
   logic signed [tae_pkg::ANGLE_W-1:0]    roll_z_ff, pitch_z_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [16:0]                    roll_ff;
   logic signed [15:0]                    pitch_ff;
   logic signed [31:0]                    yaw_ff;

   logic                                  accept, out_free, load;
   logic signed [31:0]                    ay_ext, az_ext;
   logic signed [16:0]                    ax_neg;
   logic                                  cordic_start;
   logic signed [tae_pkg::OPND_W-1:0]     cordic_y, cordic_x;
   tae_pkg::unit_status_type              cordic_stat, sqrt_stat, yaw_stat;
   logic signed [tae_pkg::ANGLE_W-1:0]    cordic_angle;
   logic                                  sqrt_start;
   logic [tae_pkg::SQRT_IN_W-1:0]         sqrt_root;
   logic signed [31:0]                    yaw_angle;
   logic signed [RND_W-1:0]               roll_rnd, pitch_rnd;

   // round to nearest (ties up) from Q16 to 1/256 degree, then clamp to +/-lim
   function automatic logic signed [RND_W-1:0] round_angle(
      input logic signed [tae_pkg::ANGLE_W-1:0] z,
      input logic signed [RND_W-1:0]            lim
   );
      logic signed [tae_pkg::ANGLE_W:0] t;
      logic signed [RND_W-1:0]          r;
      t = {z[tae_pkg::ANGLE_W-1], z} + (tae_pkg::ANGLE_W + 1)'(128);
      r = t[tae_pkg::ANGLE_W:8];
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == S_FIN) && out_free && !yaw_stat.busy;

   always_comb begin
      ay_ext = {{16{ay_ff[15]}}, ay_ff};
      az_ext = {{16{az_ff[15]}}, az_ff};
      ax_neg = -$signed({ax_ff[15], ax_ff});

      cordic_start = 1'b0;
      cordic_y     = {{4{ay_ff[15]}}, ay_ff, 16'd0};
      cordic_x     = {{4{az_ff[15]}}, az_ff, 16'd0};
      sqrt_start   = (state_ff == S_SUM);
      state_in     = state_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            // roll runs on the CORDIC while the root is worked out
            cordic_start = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_stat.done) begin
               state_in = S_PGO;
            end
         end
         S_PGO: begin
            cordic_start = 1'b1;
            cordic_y     = {{3{ax_neg[16]}}, ax_neg, 16'd0};
            cordic_x     = $signed({4'd0, sqrt_root});
            state_in     = S_PITCH;
         end
         S_PITCH: begin
            if (cordic_stat.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      roll_rnd  = round_angle(roll_z_ff, RND_W'(46080));
      pitch_rnd = round_angle(pitch_z_ff, RND_W'(23040));

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
      end
      if (state_ff == S_SQUARE) begin
         sq_y_ff <= ay_ext * ay_ext;
         sq_z_ff <= az_ext * az_ext;
      end
      if (cordic_stat.done) begin
         if (state_ff == S_PITCH) begin
            pitch_z_ff <= cordic_angle;
         end else begin
            roll_z_ff <= cordic_angle;
         end
      end
      if (load) begin
         roll_ff  <= roll_rnd[16:0];
         pitch_ff <= pitch_rnd[15:0];
         yaw_ff   <= yaw_angle;
      end
   end

   tae_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .opnd_y (cordic_y),
      .opnd_x (cordic_x),
      .status (cordic_stat),
      .angle  (cordic_angle)
   );

   tae_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_y_ff + sq_z_ff),
      .status   (sqrt_stat),
      .root     (sqrt_root)
   );

   tae_yaw u_yaw (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .gyro      (req_gyro_z),
      .status    (yaw_stat),
      .yaw_angle (yaw_angle)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   `TAE_ASSERT_IMPLIES(a_cordic_free, clock, reset, cordic_start, !cordic_stat.busy)
   `TAE_ASSERT_IMPLIES(a_yaw_in_root, clock, reset, yaw_stat.done, state_ff == S_ROOT)
   `TAE_ASSERT_NEXT(a_root_to_pitch, clock, reset, (state_ff == S_ROOT) && sqrt_stat.done, state_ff == S_PGO)
   `TAE_ASSERT_IMPLIES(a_roll_range, clock, reset, rsp_valid, (rsp_roll_angle <= 17'sd46080) && (rsp_roll_angle >= -17'sd46080))

endmodule

`default_nettype wire

// ===== design/tae_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle, returns atan2 in Q16 degrees.
// Depends on tae_pkg.
`default_nettype none

module tae_cordic #(
   parameter int ITERATIONS = tae_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [tae_pkg::OPND_W-1:0]   opnd_y,
   input  wire logic signed [tae_pkg::OPND_W-1:0]   opnd_x,
   output tae_pkg::unit_status_type                 status,
   output logic signed [tae_pkg::ANGLE_W-1:0]       angle
);

   localparam int IW = $clog2(ITERATIONS);
   localparam logic [IW-1:0] LAST = IW'(ITERATIONS - 1);

   logic                                 run_ff, run_in;
   logic                                 done_ff, done_in;
   logic [IW-1:0]                        iter_ff, iter_in;
   logic signed [tae_pkg::OPND_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [tae_pkg::ANGLE_W-1:0]   z_ff, z_in;
   logic signed [tae_pkg::OPND_W-1:0]    dx, dy;
   logic signed [tae_pkg::ANGLE_W-1:0]   step;
   logic                                 y_pos;

   always_comb begin
      dx    = y_ff >>> iter_ff;
      dy    = x_ff >>> iter_ff;
      step  = $signed({{(tae_pkg::ANGLE_W - tae_pkg::ATAN_W){1'b0}},
                       tae_pkg::atan_entry(tae_pkg::ATAN_IDX_W'(iter_ff))});
      y_pos = !y_ff[tae_pkg::OPND_W-1] && (y_ff != '0);

      run_in  = run_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;

      if (start) begin
         iter_in = '0;
         if (opnd_y == '0) begin
            z_in    = opnd_x[tae_pkg::OPND_W-1] ? tae_pkg::DEG180 : '0;
            done_in = 1'b1;
            run_in  = 1'b0;
         end else if (opnd_x == '0) begin
            z_in    = opnd_y[tae_pkg::OPND_W-1] ? -tae_pkg::DEG90 : tae_pkg::DEG90;
            done_in = 1'b1;
            run_in  = 1'b0;
         end else if (opnd_x[tae_pkg::OPND_W-1]) begin
            // rotate by 180 degrees into the right half plane
            x_in   = -opnd_x;
            y_in   = -opnd_y;
            z_in   = opnd_y[tae_pkg::OPND_W-1] ? -tae_pkg::DEG180 : tae_pkg::DEG180;
            run_in = 1'b1;
         end else begin
            x_in   = opnd_x;
            y_in   = opnd_y;
            z_in   = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (y_pos) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step;
         end
         if (iter_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign angle       = z_ff;

endmodule

`default_nettype wire

// ===== design/tae_isqrt.sv =====
// Digit-by-digit integer square root of {radicand, 32 zero bits}, one result bit per cycle.
// Depends on tae_pkg.
`default_nettype none

module tae_isqrt (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [tae_pkg::SQRT_IN_W-1:0]      radicand,
   output tae_pkg::unit_status_type                status,
   output logic [tae_pkg::SQRT_IN_W-1:0]           root
);

   localparam logic [tae_pkg::SQRT_CNT_W-1:0] LAST =
      tae_pkg::SQRT_CNT_W'(tae_pkg::SQRT_STEPS - 1);

   logic                                 run_ff, run_in;
   logic                                 done_ff, done_in;
   logic [tae_pkg::SQRT_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [tae_pkg::SQRT_IN_W-1:0]        rad_ff, rad_in;
   logic [tae_pkg::SQRT_REM_W-1:0]       rem_ff, rem_in;
   logic [tae_pkg::SQRT_IN_W-1:0]        root_ff, root_in;
   logic [tae_pkg::SQRT_REM_W-1:0]       rem_sh, trial;

   always_comb begin
      // bring down the next bit pair; zeros follow once the radicand is used up
      rem_sh = {rem_ff[tae_pkg::SQRT_REM_W-3:0], rad_ff[tae_pkg::SQRT_IN_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;

      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         rad_in = {rad_ff[tae_pkg::SQRT_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[tae_pkg::SQRT_IN_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[tae_pkg::SQRT_IN_W-2:0], 1'b0};
         end
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

`default_nettype wire

// ===== design/tae_yaw.sv =====
// Yaw integrator: gyro rate to a rounded Q16-degree increment, saturating accumulator,
// and the 1/256-degree yaw angle. Depends on tae_pkg.
`default_nettype none

module tae_yaw (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [15:0]                    gyro,
   output tae_pkg::unit_status_type                   status,
   output logic signed [tae_pkg::YAW_OUT_W-1:0]       yaw_angle
);

   localparam int NSTAGE = 6;
   localparam int ACC_X  = tae_pkg::YAW_ACC_W + 1;
   localparam int RND_W  = ACC_X - 8;

   logic [NSTAGE-1:0]                     stage_ff, stage_in;
   logic                                  neg_ff;
   logic [tae_pkg::YAW_NUM_W-1:0]         num_ff, chk_ff;
   logic [2*tae_pkg::YAW_NUM_W-1:0]       prod_ff;
   logic [tae_pkg::YAW_Q_W-1:0]           q0_ff, q_ff;
   logic signed [tae_pkg::YAW_ACC_W-1:0]  accum_ff, accum_in;
   logic signed [tae_pkg::YAW_OUT_W-1:0]  yaw_ff, yaw_in;

   logic [15:0]                           gyro_mag;
   logic [tae_pkg::YAW_NUM_W-1:0]         num_in, diff;
   logic [tae_pkg::YAW_Q_W-1:0]           q_in;
   logic signed [tae_pkg::YAW_Q_W:0]      inc;
   logic signed [ACC_X-1:0]               sum, rnd;
   logic signed [RND_W-1:0]               rnd_sh;

   always_comb begin
      stage_in = {stage_ff[NSTAGE-2:0], start};
      gyro_mag = gyro[15] ? (~gyro + 16'd1) : gyro;
      num_in   = {gyro_mag, 16'd0} + tae_pkg::YAW_HALF;

      // the reciprocal estimate is at most one short; fix it up with the remainder
      diff = num_ff - chk_ff;
      q_in = (diff >= {18'd0, tae_pkg::YAW_DIV}) ? q0_ff + 1'b1 : q0_ff;

      inc = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      sum = {accum_ff[tae_pkg::YAW_ACC_W-1], accum_ff}
            + {{(ACC_X - tae_pkg::YAW_Q_W - 1){inc[tae_pkg::YAW_Q_W]}}, inc};
      if (sum[ACC_X-1] != sum[ACC_X-2]) begin
         accum_in = sum[ACC_X-1] ? {1'b1, {(tae_pkg::YAW_ACC_W-1){1'b0}}}
                                 : {1'b0, {(tae_pkg::YAW_ACC_W-1){1'b1}}};
      end else begin
         accum_in = sum[tae_pkg::YAW_ACC_W-1:0];
      end

      rnd    = {accum_ff[tae_pkg::YAW_ACC_W-1], accum_ff} + ACC_X'(128);
      rnd_sh = rnd[ACC_X-1:8];
      if (rnd_sh[RND_W-1:tae_pkg::YAW_OUT_W-1]
          != {(RND_W - tae_pkg::YAW_OUT_W + 1){rnd_sh[tae_pkg::YAW_OUT_W-1]}}) begin
         yaw_in = rnd_sh[RND_W-1] ? {1'b1, {(tae_pkg::YAW_OUT_W-1){1'b0}}}
                                  : {1'b0, {(tae_pkg::YAW_OUT_W-1){1'b1}}};
      end else begin
         yaw_in = rnd_sh[tae_pkg::YAW_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         accum_ff <= '0;
      end else begin
         stage_ff <= stage_in;
         if (stage_ff[4]) begin
            accum_ff <= accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= gyro[15];
         num_ff <= num_in;
      end
      if (stage_ff[0]) begin
         prod_ff <= {32'd0, num_ff} * {32'd0, tae_pkg::YAW_RECIP};
      end
      if (stage_ff[1]) begin
         q0_ff <= prod_ff[tae_pkg::YAW_SHIFT +: tae_pkg::YAW_Q_W];
      end
      if (stage_ff[2]) begin
         chk_ff <= {14'd0, q0_ff} * {18'd0, tae_pkg::YAW_DIV};
      end
      if (stage_ff[3]) begin
         q_ff <= q_in;
      end
      if (stage_ff[5]) begin
         yaw_ff <= yaw_in;
      end
   end

   assign status.busy = |stage_ff;
   assign status.done = stage_ff[NSTAGE-1];
   assign yaw_angle   = yaw_ff;

endmodule

`default_nettype wire
